>>> src/swamm_pkg.sv
`timescale 1ns / 1ps

package swamm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 11;

  // one three-axis sample
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x_sample;
    logic signed [SAMPLE_W-1:0] y_sample;
    logic signed [SAMPLE_W-1:0] z_sample;
  } sample_t;

  // one result: current sample and window statistics per axis
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x_now;
    logic signed [SAMPLE_W-1:0] x_avg;
    logic signed [SAMPLE_W-1:0] x_min;
    logic signed [SAMPLE_W-1:0] x_max;
    logic signed [SAMPLE_W-1:0] y_now;
    logic signed [SAMPLE_W-1:0] y_avg;
    logic signed [SAMPLE_W-1:0] y_min;
    logic signed [SAMPLE_W-1:0] y_max;
    logic signed [SAMPLE_W-1:0] z_now;
    logic signed [SAMPLE_W-1:0] z_avg;
    logic signed [SAMPLE_W-1:0] z_min;
    logic signed [SAMPLE_W-1:0] z_max;
  } result_t;

  // control from the sequencer to the min/max scanner
  typedef struct packed {
    logic fold;   // read data from the window store is valid this cycle
    logic first;  // that data is the first entry of the window
  } scan_ctl_t;

endpackage

>>> src/swamm_div.sv
`timescale 1ns / 1ps

module swamm_div import swamm_pkg::*; #(
  parameter int SUM_W = 26,
  parameter int LEN_W = 11
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SUM_W-1:0]    dividend,
  input  logic        [LEN_W-1:0]    divisor,
  output logic                       busy,
  output logic signed [SAMPLE_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] quo;
  logic [LEN_W-1:0] rem;
  logic [LEN_W-1:0] dvs;
  logic             neg;

  logic [SUM_W-1:0] mag;
  logic [LEN_W:0]   rem_sh;
  logic [LEN_W:0]   rem_diff;
  logic             fits;
  logic [SUM_W-1:0] quo_signed;

  // magnitude of the dividend, truncation toward zero via sign fix-up
  assign mag = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

  // one restoring step per cycle
  assign rem_sh   = {rem, quo[SUM_W-1]};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign rem_diff = rem_sh - {1'b0, dvs};

  assign quo_signed = neg ? SUM_W'(~quo + SUM_W'(1)) : quo;
  assign quotient   = quo_signed[SAMPLE_W-1:0];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(SUM_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // shift/subtract datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= mag;
      rem <= '0;
      dvs <= divisor;
      neg <= dividend[SUM_W-1];
    end else if (busy) begin
      rem <= fits ? rem_diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

endmodule

>>> src/swamm_scan.sv
`timescale 1ns / 1ps

module swamm_scan import swamm_pkg::*; (
  input  logic      clk,
  input  scan_ctl_t ctl,
  input  sample_t   rd_data,
  output sample_t   lo,
  output sample_t   hi
);

  // fold one window entry per cycle into the running min and max
  always_ff @(posedge clk) begin
    if (ctl.fold) begin
      if (ctl.first) begin
        lo <= rd_data;
        hi <= rd_data;
      end else begin
        if (rd_data.x_sample < lo.x_sample) lo.x_sample <= rd_data.x_sample;
        if (rd_data.y_sample < lo.y_sample) lo.y_sample <= rd_data.y_sample;
        if (rd_data.z_sample < lo.z_sample) lo.z_sample <= rd_data.z_sample;
        if (rd_data.x_sample > hi.x_sample) hi.x_sample <= rd_data.x_sample;
        if (rd_data.y_sample > hi.y_sample) hi.y_sample <= rd_data.y_sample;
        if (rd_data.z_sample > hi.z_sample) hi.z_sample <= rd_data.z_sample;
      end
    end
  end

endmodule

>>> src/sliding_window_avg_min_max_unit.sv
`timescale 1ns / 1ps
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_data (sample_t)
// out      output     out_valid / out_ready  out_data (result_t)
// cfg      input      cfg_we                 cfg_wdata (window length, 11 bits)
//
// While the window fills, an item is a read of the oldest entry, then a write-back. Once full,
// an item also needs the min/max scan and the three averages; the min/max scan
// reads the single-port window store one entry per cycle, the three dividers run alongside.
// Synchronous reset; a config write restarts the fill phase. A waiting result sits in the
// output register while the next item is taken; only the final load waits on out_ready.

module sliding_window_avg_min_max_unit import swamm_pkg::*; #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sample_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output result_t          out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W  = SAMPLE_W + $clog2(MAX_WINDOW);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]              state;
  logic [LEN_W-1:0]        n_len;
  logic [LEN_W-1:0]        fill_count;
  logic [ADDR_W-1:0]       wp;
  logic [ADDR_W-1:0]       scan_idx;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic signed [SUM_W-1:0] sum_z;
  sample_t                 smp;
  logic                    scan_pend;
  logic                    scan_first;

  sample_t                 mem [MAX_WINDOW];
  sample_t                 mem_q;

  logic                    accept;
  logic                    full;
  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    wr_en;
  logic                    last_scan;
  logic                    wp_wrap;
  logic [31:0]             cfg_len;
  sample_t                 old;
  logic signed [SUM_W-1:0] sum_x_next;
  logic signed [SUM_W-1:0] sum_y_next;
  logic signed [SUM_W-1:0] sum_z_next;
  logic                    div_start;
  logic                    busy_x;
  logic                    busy_y;
  logic                    busy_z;
  logic                    div_busy;
  logic signed [SAMPLE_W-1:0] q_x;
  logic signed [SAMPLE_W-1:0] q_y;
  logic signed [SAMPLE_W-1:0] q_z;
  scan_ctl_t               scan_ctl;
  sample_t                 lo;
  sample_t                 hi;
  logic                    out_load;

  // handshake and status
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign full      = (fill_count == n_len);
  assign last_scan = (LEN_W'(scan_idx) == n_len - LEN_W'(1));
  assign wp_wrap   = (LEN_W'(wp) + LEN_W'(1) == n_len);
  assign div_busy  = busy_x || busy_y || busy_z;
  assign out_load  = (state == ST_DONE) && !div_busy && (!out_valid || out_ready);

  // effective window length: zero means one, clamp to store depth
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_len = 32'd1;
    end else if (32'(cfg_wdata) > 32'(MAX_WINDOW)) begin
      cfg_len = 32'(MAX_WINDOW);
    end else begin
      cfg_len = 32'(cfg_wdata);
    end
  end

  // store port control: oldest entry on accept, window entries during scan
  assign rd_en   = accept || (state == ST_SCAN);
  assign rd_addr = (state == ST_SCAN) ? scan_idx : wp;
  assign wr_en   = (state == ST_FETCH);

  // window store, one entry holds all three axes
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp] <= smp;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // running sums: drop the evicted sample once the window is full
  assign old        = full ? mem_q : '0;
  assign sum_x_next = sum_x + SUM_W'(smp.x_sample) - SUM_W'(old.x_sample);
  assign sum_y_next = sum_y + SUM_W'(smp.y_sample) - SUM_W'(old.y_sample);
  assign sum_z_next = sum_z + SUM_W'(smp.z_sample) - SUM_W'(old.z_sample);
  assign div_start  = (state == ST_FETCH) && full;

  // sample capture
  always_ff @(posedge clk) begin
    if (accept) begin
      smp <= in_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      n_len      <= LEN_W'(1);
      fill_count <= '0;
      wp         <= '0;
      sum_x      <= '0;
      sum_y      <= '0;
      sum_z      <= '0;
      scan_idx   <= '0;
      scan_pend  <= 1'b0;
      scan_first <= 1'b0;
    end else begin
      scan_pend  <= (state == ST_SCAN);
      scan_first <= (state == ST_SCAN) && (scan_idx == '0);
      if (cfg_we) begin
        n_len      <= cfg_len[LEN_W-1:0];
        fill_count <= '0;
        wp         <= '0;
        sum_x      <= '0;
        sum_y      <= '0;
        sum_z      <= '0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          sum_x <= sum_x_next;
          sum_y <= sum_y_next;
          sum_z <= sum_z_next;
          wp    <= wp_wrap ? '0 : wp + ADDR_W'(1);
          if (full) begin
            scan_idx <= '0;
            state    <= ST_SCAN;
          end else begin
            fill_count <= fill_count + LEN_W'(1);
            state      <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          scan_idx <= scan_idx + ADDR_W'(1);
          if (last_scan) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // min/max scanner
  assign scan_ctl.fold  = scan_pend;
  assign scan_ctl.first = scan_first;

  swamm_scan u_scan (
    .clk     (clk),
    .ctl     (scan_ctl),
    .rd_data (mem_q),
    .lo      (lo),
    .hi      (hi)
  );

  // averages, one divider per axis
  swamm_div #(.SUM_W(SUM_W), .LEN_W(LEN_W)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_x_next),
    .divisor  (n_len),
    .busy     (busy_x),
    .quotient (q_x)
  );

  swamm_div #(.SUM_W(SUM_W), .LEN_W(LEN_W)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_y_next),
    .divisor  (n_len),
    .busy     (busy_y),
    .quotient (q_y)
  );

  swamm_div #(.SUM_W(SUM_W), .LEN_W(LEN_W)) u_div_z (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_z_next),
    .divisor  (n_len),
    .busy     (busy_z),
    .quotient (q_z)
  );

  // output register: valid control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register: payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= '{x_now: smp.x_sample, x_avg: q_x, x_min: lo.x_sample, x_max: hi.x_sample,
                    y_now: smp.y_sample, y_avg: q_y, y_min: lo.y_sample, y_max: hi.y_sample,
                    z_now: smp.z_sample, z_avg: q_z, z_min: lo.z_sample, z_max: hi.z_sample};
    end
  end

  // fill count never passes the window length
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= n_len)
    else $error("fill count beyond window length");

  // write pointer stays inside the active window
  a_wp_bound: assert property (@(posedge clk) disable iff (rst)
    LEN_W'(wp) < n_len)
    else $error("write pointer outside window");

  // dividers are only started from an idle state
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // a result is only produced for an item that found the window full
  a_scan_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) && !full |=> (state == ST_IDLE) && !scan_pend)
    else $error("scan started during fill phase");

endmodule

>>> tb/sv/sliding_window_avg_min_max_unit_tb.sv
`timescale 1ns / 1ps

module sliding_window_avg_min_max_unit_tb;
  import swamm_pkg::*;

  localparam int WIN_DEPTH  = 1024;
  localparam int NFIELD     = 12;
  localparam int RES_W      = $bits(result_t);
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_PAD = 40;
  localparam int HOLD_LEN   = 600;
  localparam int REPORT_MAX = 10;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  typedef enum {ROW_CFG, ROW_PREDICT, ROW_SINGLE} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [CFG_W-1:0] len;
    sample_t          smp;
  } stim_row_t;

  logic             clk;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  sample_t          in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  result_t          out_data;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // window statistics model
  logic signed [SAMPLE_W-1:0] hist [3][WIN_DEPTH];
  longint                     axis_sum [3];
  int unsigned                fill_seen;
  int unsigned                wr_slot;
  logic [CFG_W-1:0]           len_reg;

  result_t     expected_stats [$];
  result_t     want_stats;
  stim_row_t   dir_rows [$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles  = 0;
  int unsigned in_idle_pct  = 0;
  int unsigned out_stall_pct = 0;
  int          hold_left    = 0;
  int          fk;

  string field_names [NFIELD] = '{"x_now", "x_avg", "x_min", "x_max",
                                  "y_now", "y_avg", "y_min", "y_max",
                                  "z_now", "z_avg", "z_min", "z_max"};

  sliding_window_avg_min_max_unit #(
    .MAX_WINDOW(WIN_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // window length as the block uses it
  function automatic int unsigned window_eff();
    int unsigned n;
    n = 32'(len_reg);
    if (n == 0) n = 1;
    if (n > WIN_DEPTH) n = WIN_DEPTH;
    return n;
  endfunction

  function automatic void restart_window(input logic [CFG_W-1:0] len);
    len_reg   = len;
    fill_seen = 0;
    wr_slot   = 0;
    axis_sum  = '{0, 0, 0};
  endfunction

  // store one sample, return 1 with the stats once the window is full
  function automatic bit advance_window(input sample_t s, output result_t stats);
    int unsigned n;
    int a, i;
    bit full;
    logic signed [SAMPLE_W-1:0] v [3];
    logic signed [SAMPLE_W-1:0] lo_v [3];
    logic signed [SAMPLE_W-1:0] hi_v [3];
    logic signed [SAMPLE_W-1:0] avg_v [3];
    n    = window_eff();
    full = (fill_seen >= n);
    v[0] = s.x_sample;
    v[1] = s.y_sample;
    v[2] = s.z_sample;
    stats = '0;
    if (wr_slot >= n) wr_slot = 0;
    for (a = 0; a < 3; a++) begin
      if (full) axis_sum[a] = axis_sum[a] - longint'(hist[a][wr_slot]);
      axis_sum[a] = axis_sum[a] + longint'(v[a]);
      hist[a][wr_slot] = v[a];
    end
    wr_slot++;
    if (wr_slot >= n) wr_slot = 0;
    if (!full) begin
      fill_seen++;
      return 1'b0;
    end
    // min/max scan and truncating average per axis
    for (a = 0; a < 3; a++) begin
      lo_v[a] = hist[a][0];
      hi_v[a] = hist[a][0];
      for (i = 1; i < n; i++) begin
        if (hist[a][i] > hi_v[a]) hi_v[a] = hist[a][i];
        if (hist[a][i] < lo_v[a]) lo_v[a] = hist[a][i];
      end
      avg_v[a] = SAMPLE_W'(axis_sum[a] / longint'(n));
    end
    stats = {v[0], avg_v[0], lo_v[0], hi_v[0],
             v[1], avg_v[1], lo_v[1], hi_v[1],
             v[2], avg_v[2], lo_v[2], hi_v[2]};
    return 1'b1;
  endfunction

  // extremes, small values near zero, or anything
  function automatic logic signed [SAMPLE_W-1:0] rand_field();
    case ($urandom_range(7))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2:       return '0;
      3:       return SAMPLE_W'(int'($urandom_range(16)) - 8);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.x_sample = rand_field();
    s.y_sample = rand_field();
    s.z_sample = rand_field();
    return s;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("%s", msg);
  endtask

  task automatic add_row(input row_kind_t kind, input int len, input int x, input int y,
                         input int z);
    stim_row_t r;
    r.kind         = kind;
    r.len          = CFG_W'(len);
    r.smp.x_sample = SAMPLE_W'(x);
    r.smp.y_sample = SAMPLE_W'(y);
    r.smp.z_sample = SAMPLE_W'(z);
    dir_rows.push_back(r);
  endtask

  // one sample transfer; called and returns at a falling edge
  task automatic push_sample(input sample_t s, input bit single);
    result_t stats;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (advance_window(s, stats)) begin
      // a window of one: every field of an axis is the sample itself
      if (single)
        stats = {{4{s.x_sample}}, {4{s.y_sample}}, {4{s.z_sample}}};
      expected_stats.push_back(stats);
    end
    @(negedge clk);
  endtask

  // drain, let a trailing fill item finish, then write the window length
  task automatic write_window(input logic [CFG_W-1:0] len);
    in_valid <= 1'b0;
    while (expected_stats.size() != 0) @(negedge clk);
    repeat (window_eff() + SETTLE_PAD) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
    restart_window(len);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] len, input int unsigned count,
                           input int unsigned in_pct, input int unsigned out_pct,
                           input bit squeeze);
    int unsigned j;
    write_window(len);
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
    for (j = 0; j < count; j++) begin
      if (squeeze && j == count / 2) hold_left = HOLD_LEN;
      push_sample(rand_sample(), 1'b0);
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      results_seen++;
      if (expected_stats.size() == 0) begin
        note_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want_stats = expected_stats.pop_front();
        for (fk = 0; fk < NFIELD; fk++) begin
          if (out_data[RES_W-1-fk*SAMPLE_W -: SAMPLE_W] !==
              want_stats[RES_W-1-fk*SAMPLE_W -: SAMPLE_W])
            note_mismatch($sformatf("result %0d %s: expected %0d got %0d", results_seen,
                          field_names[fk],
                          $signed(want_stats[RES_W-1-fk*SAMPLE_W -: SAMPLE_W]),
                          $signed(out_data[RES_W-1-fk*SAMPLE_W -: SAMPLE_W])));
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    restart_window(CFG_W'(1));

    // directed rows: window of one after reset
    add_row(ROW_PREDICT, 0, 0, 0, 0);
    add_row(ROW_SINGLE, 0, 32767, -32768, 0);
    add_row(ROW_SINGLE, 0, -32768, 32767, -1);
    add_row(ROW_SINGLE, 0, 21845, -21846, 1);
    add_row(ROW_SINGLE, 0, -21846, 21845, -32768);
    // length zero acts as one
    add_row(ROW_CFG, 0, 0, 0, 0);
    add_row(ROW_PREDICT, 0, 100, -100, 7);
    add_row(ROW_SINGLE, 0, -1, 32767, 0);
    // window of two: extreme sums, truncation toward zero
    add_row(ROW_CFG, 2, 0, 0, 0);
    add_row(ROW_PREDICT, 0, 32767, -32768, 32767);
    add_row(ROW_PREDICT, 0, 32767, -32768, -32768);
    add_row(ROW_PREDICT, 0, -32768, 32767, -32768);
    add_row(ROW_PREDICT, 0, -3, 4, -5);
    // window of three: negative averages
    add_row(ROW_CFG, 3, 0, 0, 0);
    add_row(ROW_PREDICT, 0, -7, 7, 0);
    add_row(ROW_PREDICT, 0, 0, 0, 0);
    add_row(ROW_PREDICT, 0, 0, 0, 0);
    add_row(ROW_PREDICT, 0, -1, 1, 32767);
    add_row(ROW_PREDICT, 0, -8, 8, -32768);
    add_row(ROW_PREDICT, 0, 32767, -32768, 1);
    add_row(ROW_PREDICT, 0, -32768, 32767, -1);
    // rewrite to length one restarts the fill
    add_row(ROW_CFG, 1, 0, 0, 0);
    add_row(ROW_PREDICT, 0, 5, 5, 5);
    add_row(ROW_SINGLE, 0, -32768, -32768, 32767);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_window(dir_rows[i].len);
      else
        push_sample(dir_rows[i].smp, dir_rows[i].kind == ROW_SINGLE);
    end

    // random phases over short and medium windows
    run_phase(CFG_W'($urandom_range(4, 8)), 100, 0, 0, 1'b0);
    run_phase(CFG_W'($urandom_range(9, 40)), 100, 53, 0, 1'b0);
    run_phase(CFG_W'($urandom_range(2, 24)), 100, 0, 53, 1'b0);
    run_phase(CFG_W'($urandom_range(2, 16)), 100, 15, 15, 1'b1);
    run_phase(CFG_W'($urandom_range(1, 64)), 120, 0, 53, 1'b0);

    // drain and let the block go quiet
    in_valid <= 1'b0;
    while (expected_stats.size() != 0) @(negedge clk);
    repeat (window_eff() + SETTLE_PAD) @(negedge clk);

    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
